>>> hw/rtl/assert_macros.svh
// Assertion macros used by the RTL of the LFU cache replacement unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every rising edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Expression must never be true at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

>>> hw/rtl/lfu_pkg.sv
// Package with constants and payload types of the LFU cache replacement unit.
package lfu_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int KEY_WIDTH   = 32;
	localparam int VALUE_WIDTH = 32;
	localparam int COUNT_WIDTH = 16;
	localparam int CAP_W       = 7;

	localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int RANK_W = IDX_W;
	// Holds counts from zero up to MAX_ENTRIES inclusive.
	localparam int FILL_W = IDX_W + 1;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

	localparam logic ACT_GET = 1'b0;
	localparam logic ACT_PUT = 1'b1;

	typedef struct packed {
		logic                   action;
		logic [KEY_WIDTH-1:0]   key;
		logic [VALUE_WIDTH-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic                   hit;
		logic [VALUE_WIDTH-1:0] read_value;
		logic                   evicted;
		logic [KEY_WIDTH-1:0]   evicted_key;
	} out_item_t;

	typedef struct packed {
		logic [KEY_WIDTH-1:0]   key;
		logic [VALUE_WIDTH-1:0] value;
		logic [COUNT_WIDTH-1:0] count;
		logic [RANK_W-1:0]      rank;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

>>> hw/rtl/lfu_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module lfu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hw/rtl/lfu_cache_replacement_unit.sv
// Top level of the LFU cache replacement unit: control, entry scan and result register.
//
// Usage: a fully associative key/value store of 64 entries with least-frequently-used
// replacement, ties going to the least recently used entry. Each input transfer on
// in_valid/in_stall/in_data is a get or a put; each produces exactly one result transfer
// on out_valid/out_stall/out_data carrying the hit flag, the read value and the key of
// any evicted entry. The capacity register is written through cfg_we/cfg_wdata; the user must
// write it only while the unit is idle, not enforced by the block. Over 64 acts as 64, zero disables inserts.
// Timing: one item is in work at a time. After acceptance the unit sweeps the whole
// entry RAM, one read per cycle through its single read port, then decides and writes
// the chosen entry back and passes the result to the output register; a new item is
// accepted only after that result has been loaded there. The RAM read port and the
// 64-entry sweep set the time per item. Recency updates left by one item are applied
// to the ranks during the sweep of the next item, so they need no pass of their own.
// Reset clears the valid bits, the fill count and the pending recency update and sets
// capacity to 64; the RAM contents are never cleared since only valid entries are used.
// When the receiver stalls, the result stays in the output register and the next item
// is still accepted and processed; it then waits until the output register is free.
module lfu_cache_replacement_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  lfu_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output lfu_pkg::out_item_t            out_data,
	input  logic                          cfg_we,
	input  logic [lfu_pkg::CAP_W-1:0]     cfg_wdata
);

`include "assert_macros.svh"

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH,
		ST_DELIVER
	} state_t;

	state_t state_q;

	// Control state.
	logic [lfu_pkg::CAP_W-1:0]       capacity_q;
	logic [lfu_pkg::FILL_W-1:0]      fill_q;
	logic [lfu_pkg::MAX_ENTRIES-1:0] valid_q;
	logic [lfu_pkg::FILL_W-1:0]      pend_thr_q;
	logic [lfu_pkg::FILL_W-1:0]      rd_idx_q;
	logic                            vld_s1;
	logic                            found_q;
	logic                            free_found_q;
	logic                            vict_found_q;

	// Datapath registers.
	lfu_pkg::in_item_t               item_q;
	logic [lfu_pkg::IDX_W-1:0]       idx_s1;
	logic [lfu_pkg::IDX_W-1:0]       pend_slot_q;
	logic [lfu_pkg::IDX_W-1:0]       found_idx_q;
	logic [lfu_pkg::VALUE_WIDTH-1:0] found_val_q;
	logic [lfu_pkg::COUNT_WIDTH-1:0] found_cnt_q;
	logic [lfu_pkg::RANK_W-1:0]      found_rank_q;
	logic [lfu_pkg::IDX_W-1:0]       free_idx_q;
	logic [lfu_pkg::IDX_W-1:0]       vict_idx_q;
	logic [lfu_pkg::COUNT_WIDTH-1:0] vict_cnt_q;
	logic [lfu_pkg::RANK_W-1:0]      vict_rank_q;
	logic [lfu_pkg::KEY_WIDTH-1:0]   vict_key_q;
	lfu_pkg::out_item_t              res_q;

	// RAM ports.
	logic                            ram_we;
	logic [lfu_pkg::IDX_W-1:0]       ram_waddr;
	logic [lfu_pkg::ENTRY_W-1:0]     ram_wdata;
	logic                            ram_re;
	logic [lfu_pkg::IDX_W-1:0]       ram_raddr;
	logic [lfu_pkg::ENTRY_W-1:0]     ram_rdata;

	// Scan stage signals.
	lfu_pkg::entry_t                 rd_entry;
	lfu_pkg::entry_t                 scan_entry;
	logic                            ent_valid;
	logic [lfu_pkg::RANK_W-1:0]      rank_upd;
	logic                            hit_now;
	logic                            free_now;
	logic                            take_vict;
	logic                            last_s1;
	logic                            scan_we;

	// Decision signals.
	logic                            is_put;
	logic [lfu_pkg::FILL_W-1:0]      cap_eff;
	lfu_pkg::out_item_t              res_d;
	lfu_pkg::entry_t                 new_entry;
	logic                            do_write;
	logic                            do_fill;
	logic [lfu_pkg::IDX_W-1:0]       slot_d;
	logic [lfu_pkg::FILL_W-1:0]      next_thr;
	logic                            fin_we;
	logic                            out_load;

	lfu_ram #(
		.WIDTH (lfu_pkg::ENTRY_W),
		.DEPTH (lfu_pkg::MAX_ENTRIES)
	) u_entry_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign in_stall = (state_q != ST_IDLE);
	assign out_load = (state_q == ST_DELIVER) && (!out_valid || !out_stall);

	// The read pointer walks every entry once per item.
	assign ram_re    = (state_q == ST_SCAN) && (rd_idx_q < lfu_pkg::FILL_W'(lfu_pkg::MAX_ENTRIES));
	assign ram_raddr = rd_idx_q[lfu_pkg::IDX_W-1:0];

	// An entry read back is aged by the recency update that the previous item left pending:
	// a rank below the threshold moves one place older, the touched slot itself stays.
	assign rd_entry  = lfu_pkg::entry_t'(ram_rdata);
	assign ent_valid = valid_q[idx_s1];
	assign rank_upd  = (ent_valid && (idx_s1 != pend_slot_q) &&
		(lfu_pkg::FILL_W'(rd_entry.rank) < pend_thr_q)) ?
		lfu_pkg::RANK_W'(rd_entry.rank + 1'b1) : rd_entry.rank;

	assign hit_now   = vld_s1 && ent_valid && (rd_entry.key == item_q.key);
	assign free_now  = vld_s1 && !ent_valid && !free_found_q;
	assign take_vict = vld_s1 && ent_valid && (!vict_found_q ||
		(rd_entry.count < vict_cnt_q) ||
		((rd_entry.count == vict_cnt_q) && (rank_upd > vict_rank_q)));
	assign last_s1   = vld_s1 && (idx_s1 == lfu_pkg::IDX_W'(lfu_pkg::MAX_ENTRIES - 1));
	assign scan_we   = vld_s1 && ent_valid;

	always_comb begin
		scan_entry      = rd_entry;
		scan_entry.rank = rank_upd;
	end

	// Decision at the end of the sweep: update of a present key, fill of a free slot,
	// eviction of the least used, oldest entry, or no write for a missed get or zero capacity.
	always_comb begin
		is_put  = (item_q.action == lfu_pkg::ACT_PUT);
		cap_eff = (32'(capacity_q) > 32'(lfu_pkg::MAX_ENTRIES)) ?
			lfu_pkg::FILL_W'(lfu_pkg::MAX_ENTRIES) : lfu_pkg::FILL_W'(capacity_q);
		res_d           = '0;
		new_entry.key   = item_q.key;
		new_entry.value = item_q.value;
		new_entry.count = lfu_pkg::COUNT_WIDTH'(1);
		new_entry.rank  = '0;
		do_write        = 1'b0;
		do_fill         = 1'b0;
		slot_d          = found_idx_q;
		next_thr        = '0;
		if (found_q) begin
			res_d.hit = 1'b1;
			if (!is_put) begin
				res_d.read_value = found_val_q;
				new_entry.value  = found_val_q;
			end
			new_entry.count = (&found_cnt_q) ? found_cnt_q :
				lfu_pkg::COUNT_WIDTH'(found_cnt_q + 1'b1);
			do_write = 1'b1;
			next_thr = lfu_pkg::FILL_W'(found_rank_q);
		end else if (is_put && (cap_eff != '0)) begin
			if ((fill_q < cap_eff) && free_found_q) begin
				slot_d   = free_idx_q;
				do_write = 1'b1;
				do_fill  = 1'b1;
				next_thr = lfu_pkg::FILL_W'(lfu_pkg::MAX_ENTRIES);
			end else if (vict_found_q) begin
				// Dropping the victim and inserting fresh ages exactly the ranks below it.
				slot_d            = vict_idx_q;
				do_write          = 1'b1;
				res_d.evicted     = 1'b1;
				res_d.evicted_key = vict_key_q;
				next_thr          = lfu_pkg::FILL_W'(vict_rank_q);
			end
		end
	end

	assign fin_we    = (state_q == ST_FINISH) && do_write;
	assign ram_we    = scan_we || fin_we;
	assign ram_waddr = scan_we ? idx_s1 : slot_d;
	assign ram_wdata = scan_we ? lfu_pkg::ENTRY_W'(scan_entry) : lfu_pkg::ENTRY_W'(new_entry);

	// State machine, control state and registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			out_valid    <= 1'b0;
			out_data     <= '0;
			capacity_q   <= lfu_pkg::CAP_RESET;
			fill_q       <= '0;
			valid_q      <= '0;
			pend_thr_q   <= '0;
			rd_idx_q     <= '0;
			vld_s1       <= 1'b0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			vict_found_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			// A new result loads when the register is empty or its transfer happens now.
			if (out_load) begin
				out_valid <= 1'b1;
				out_data  <= res_q;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			vld_s1 <= ram_re;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q      <= ST_SCAN;
						rd_idx_q     <= '0;
						found_q      <= 1'b0;
						free_found_q <= 1'b0;
						vict_found_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (ram_re) begin
						rd_idx_q <= lfu_pkg::FILL_W'(rd_idx_q + 1'b1);
					end
					if (hit_now) begin
						found_q <= 1'b1;
					end
					if (free_now) begin
						free_found_q <= 1'b1;
					end
					if (take_vict) begin
						vict_found_q <= 1'b1;
					end
					if (last_s1) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (do_write) begin
						valid_q[slot_d] <= 1'b1;
					end
					if (do_fill) begin
						fill_q <= lfu_pkg::FILL_W'(fill_q + 1'b1);
					end
					pend_thr_q <= next_thr;
					state_q    <= ST_DELIVER;
				end
				ST_DELIVER: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload and scan capture registers.
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && in_valid) begin
			item_q <= in_data;
		end
		idx_s1 <= ram_raddr;
		if (hit_now) begin
			found_idx_q  <= idx_s1;
			found_val_q  <= rd_entry.value;
			found_cnt_q  <= rd_entry.count;
			found_rank_q <= rank_upd;
		end
		if (free_now) begin
			free_idx_q <= idx_s1;
		end
		if (take_vict) begin
			vict_idx_q  <= idx_s1;
			vict_cnt_q  <= rd_entry.count;
			vict_rank_q <= rank_upd;
			vict_key_q  <= rd_entry.key;
		end
		if (state_q == ST_FINISH) begin
			res_q       <= res_d;
			pend_slot_q <= slot_d;
		end
	end

	`ASSERT_HOLDS(a_fill_matches_valid, clk, arst_n, 32'(fill_q) == $countones(valid_q), "fill count off")
	`ASSERT_NEVER(a_no_rw_same_entry, clk, arst_n, ram_we && ram_re && (ram_waddr == ram_raddr), "entry clash")
	`ASSERT_HOLDS(a_result_after_deliver, clk, arst_n, $rose(out_valid) |-> ($past(state_q) == ST_DELIVER), "stray result")

endmodule

>>> tb/lfu_result_checker.sv
// Checker that predicts and compares the results of the LFU cache replacement unit.
`timescale 1ns / 1ps

module lfu_result_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  lfu_pkg::in_item_t         in_data,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  lfu_pkg::out_item_t        out_data,
	input  logic                      cfg_we,
	input  logic [lfu_pkg::CAP_W-1:0] cfg_wdata,
	output int                        pending,
	output int                        errors
);

	// Age given to an entry that is being inserted, older than any valid one.
	localparam int AGE_FRESH = lfu_pkg::MAX_ENTRIES + 1;

	logic                            slot_used [lfu_pkg::MAX_ENTRIES];
	logic [lfu_pkg::KEY_WIDTH-1:0]   slot_key  [lfu_pkg::MAX_ENTRIES];
	logic [lfu_pkg::VALUE_WIDTH-1:0] slot_val  [lfu_pkg::MAX_ENTRIES];
	logic [lfu_pkg::COUNT_WIDTH-1:0] slot_uses [lfu_pkg::MAX_ENTRIES];
	int                              slot_age  [lfu_pkg::MAX_ENTRIES];
	int                              occupied;
	int                              cap_setting;
	lfu_pkg::out_item_t              expected_results [$];

	function automatic void make_newest(input int s, input bit fresh);
		int old_age;
		int i;
		old_age = fresh ? AGE_FRESH : slot_age[s];
		for (i = 0; i < lfu_pkg::MAX_ENTRIES; i++) begin
			if (i != s && slot_used[i] && slot_age[i] < old_age)
				slot_age[i]++;
		end
		slot_age[s] = 0;
	endfunction

	function automatic void retire(input int s);
		int i;
		slot_used[s] = 1'b0;
		for (i = 0; i < lfu_pkg::MAX_ENTRIES; i++) begin
			if (slot_used[i] && slot_age[i] > slot_age[s])
				slot_age[i]--;
		end
	endfunction

	function automatic lfu_pkg::out_item_t lfu_access(input lfu_pkg::in_item_t item);
		lfu_pkg::out_item_t res;
		int                 found;
		int                 victim;
		int                 eff_cap;
		int                 i;
		res     = '0;
		found   = -1;
		eff_cap = (cap_setting > lfu_pkg::MAX_ENTRIES) ? lfu_pkg::MAX_ENTRIES : cap_setting;
		for (i = 0; i < lfu_pkg::MAX_ENTRIES; i++) begin
			if (found < 0 && slot_used[i] && slot_key[i] == item.key)
				found = i;
		end
		if (found >= 0) begin
			res.hit = 1'b1;
			if (item.action == lfu_pkg::ACT_GET)
				res.read_value = slot_val[found];
			else
				slot_val[found] = item.value;
			if (slot_uses[found] != '1)
				slot_uses[found] = lfu_pkg::COUNT_WIDTH'(slot_uses[found] + 1'b1);
			make_newest(found, 1'b0);
		end else if (item.action == lfu_pkg::ACT_PUT && eff_cap > 0) begin
			victim = -1;
			if (occupied < eff_cap) begin
				for (i = 0; i < lfu_pkg::MAX_ENTRIES; i++) begin
					if (victim < 0 && !slot_used[i])
						victim = i;
				end
				if (victim >= 0)
					occupied++;
			end
			if (victim < 0) begin
				// Lowest use count wins; among equal counts the oldest entry goes.
				for (i = 0; i < lfu_pkg::MAX_ENTRIES; i++) begin
					if (slot_used[i]) begin
						if (victim < 0)
							victim = i;
						else if (slot_uses[i] < slot_uses[victim] ||
							(slot_uses[i] == slot_uses[victim] &&
							 slot_age[i] > slot_age[victim]))
							victim = i;
					end
				end
				if (victim >= 0) begin
					res.evicted     = 1'b1;
					res.evicted_key = slot_key[victim];
					retire(victim);
				end
			end
			if (victim >= 0) begin
				slot_used[victim] = 1'b1;
				slot_key[victim]  = item.key;
				slot_val[victim]  = item.value;
				slot_uses[victim] = lfu_pkg::COUNT_WIDTH'(1);
				make_newest(victim, 1'b1);
			end
		end
		return res;
	endfunction

	task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		lfu_pkg::out_item_t want;
		if (!arst_n) begin
			for (int i = 0; i < lfu_pkg::MAX_ENTRIES; i++) begin
				slot_used[i] = 1'b0;
				slot_age[i]  = 0;
			end
			occupied    = 0;
			cap_setting = 32'(lfu_pkg::CAP_RESET);
			errors      = 0;
			expected_results.delete();
			pending <= 0;
		end else begin
			// Results are retired before the input of the same edge is predicted,
			// so a result can never be matched against its own input.
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, got hit %b value %h evicted %b key %h",
						$time, out_data.hit, out_data.read_value, out_data.evicted,
						out_data.evicted_key);
				end else begin
					want = expected_results.pop_front();
					report("hit", 32'(want.hit), 32'(out_data.hit));
					report("read_value", want.read_value, out_data.read_value);
					report("evicted", 32'(want.evicted), 32'(out_data.evicted));
					report("evicted_key", want.evicted_key, out_data.evicted_key);
				end
			end
			if (cfg_we)
				cap_setting = 32'(cfg_wdata);
			if (in_valid && !in_stall)
				expected_results.push_back(lfu_access(in_data));
			pending <= expected_results.size();
		end
	end

endmodule

>>> tb/tb_top.sv
// Top of the testbench: clock, reset, stimulus and verdict for the LFU cache replacement unit.
`timescale 1ns / 1ps

module tb_top;

	// Chance in percent that the receiver stalls or the sender leaves a gap.
	localparam int STALL_PCT      = 8;
	// Cycles without any transfer before the run is declared hung. This leaves a wide
	// margin over the time one item takes, for stalls and idle gaps.
	localparam int WATCHDOG_LIMIT = 2000;
	// Quiet cycles at the end in which a stray result would still be caught.
	localparam int SETTLE_CYCLES  = 100;
	localparam int PHASE_ITEMS    = 150;
	localparam int POOL_SIZE      = 80;

	logic                          clk;
	logic                          arst_n    = 1'b0;
	logic                          in_valid  = 1'b0;
	logic                          in_stall;
	lfu_pkg::in_item_t             in_data   = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	lfu_pkg::out_item_t            out_data;
	logic                          cfg_we    = 1'b0;
	logic [lfu_pkg::CAP_W-1:0]     cfg_wdata = '0;
	logic                          calm      = 1'b0;
	int                            pending;
	int                            errors;
	int                            quiet_cycles = 0;
	logic [lfu_pkg::KEY_WIDTH-1:0] key_pool [POOL_SIZE];

	lfu_cache_replacement_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// The checker sees every transfer on both channels and every capacity write.
	lfu_result_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.pending   (pending),
		.errors    (errors)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The receiver stalls at random, except during the calm stretch.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= calm ? 1'b0 : ($urandom_range(99) < STALL_PCT);
	end

	// Watchdog: a hung block stops transferring on both channels.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// Offer one access and hold it until the block takes it. Before the transfer
	// the sender may leave a random gap with valid low. Valid stays high from one
	// transfer into the next when no gap is taken.
	task automatic offer(input logic act, input logic [lfu_pkg::KEY_WIDTH-1:0] k,
		input logic [lfu_pkg::VALUE_WIDTH-1:0] v);
		lfu_pkg::in_item_t item;
		item.action = act;
		item.key    = k;
		item.value  = v;
		if (!calm && $urandom_range(99) < STALL_PCT) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 50);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (in_stall);
	endtask

	// Stop sending and wait until the checker holds no outstanding expectation.
	// The first edge lets the checker record a transfer made at the current edge.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Every item returns a result, so an empty expectation queue means the block
	// is idle and the capacity register may be written.
	task automatic set_capacity(input int cap);
		drain();
		repeat (2) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= lfu_pkg::CAP_W'(cap);
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// One random phase under one capacity. Keys come mostly from a pool a little
	// larger than the capacity, so hits, updates and evictions all happen; a few
	// hot keys build up high use counts and a tenth of the keys are fully random.
	task automatic run_phase(input int cap, input int items, input bit pause_midway);
		int   eff_cap;
		int   span;
		int   idx;
		int   i;
		logic act;
		set_capacity(cap);
		eff_cap = (cap > lfu_pkg::MAX_ENTRIES) ? lfu_pkg::MAX_ENTRIES : cap;
		span    = (eff_cap == 0) ? 12 : eff_cap + $urandom_range(2, 12);
		// Refresh part of the pool so that key bits keep changing between phases.
		for (i = 0; i < 16; i++)
			key_pool[$urandom_range(POOL_SIZE - 1)] = $urandom;
		for (i = 0; i < items; i++) begin
			if (pause_midway && i == items / 2)
				drain();
			case ($urandom_range(9))
				0:       idx = -1;
				1, 2, 3: idx = $urandom_range(3);
				default: idx = $urandom_range(span - 1);
			endcase
			act = 1'($urandom_range(1));
			offer(act, (idx < 0) ? $urandom : key_pool[idx], $urandom);
		end
	endtask

	initial begin
		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Start on an empty table with the full capacity and use
		// the all-zero and all-one keys and values.
		set_capacity(64);
		offer(lfu_pkg::ACT_GET, 32'h0000_0000, 32'h0000_0000);	// miss on an empty table
		offer(lfu_pkg::ACT_PUT, 32'h0000_0000, 32'h0000_0000);
		offer(lfu_pkg::ACT_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		offer(lfu_pkg::ACT_GET, 32'hFFFF_FFFF, 32'h0000_0000);
		offer(lfu_pkg::ACT_GET, 32'h0000_0000, 32'hFFFF_FFFF);	// value of a get is ignored
		offer(lfu_pkg::ACT_PUT, 32'h0000_0000, 32'h5A5A_A5A5);	// update of a present key
		offer(lfu_pkg::ACT_GET, 32'h0000_0000, 32'h0000_0000);

		// Zero capacity: a new key is dropped, present keys still work.
		set_capacity(0);
		offer(lfu_pkg::ACT_PUT, 32'h1234_5678, 32'h0000_0001);
		offer(lfu_pkg::ACT_GET, 32'h1234_5678, 32'h0000_0000);
		offer(lfu_pkg::ACT_PUT, 32'hFFFF_FFFF, 32'hDEAD_BEEF);

		// Small capacity: fill the last slot, then evict by lowest use count.
		set_capacity(3);
		offer(lfu_pkg::ACT_PUT, 32'h0000_0001, 32'h0000_0011);
		offer(lfu_pkg::ACT_PUT, 32'h0000_0002, 32'h0000_0022);
		offer(lfu_pkg::ACT_PUT, 32'h0000_0003, 32'h0000_0033);
		offer(lfu_pkg::ACT_GET, 32'h0000_0003, 32'h0000_0000);
		offer(lfu_pkg::ACT_PUT, 32'h0000_0004, 32'h0000_0044);

		// Capacity lowered below the fill count: nothing is flushed and every new
		// key replaces one entry.
		set_capacity(1);
		offer(lfu_pkg::ACT_PUT, 32'h0000_0006, 32'h0000_0066);
		offer(lfu_pkg::ACT_PUT, 32'h0000_0007, 32'h0000_0077);
		offer(lfu_pkg::ACT_GET, 32'h0000_0004, 32'h0000_0000);

		// Capacity above the table size acts as the table size, so free slots fill.
		set_capacity(127);
		offer(lfu_pkg::ACT_PUT, 32'h0000_0008, 32'h0000_0088);
		offer(lfu_pkg::ACT_GET, 32'h0000_0008, 32'h0000_0000);

		// Use counts stay far below saturation in a run of this length; the
		// predictor still clamps them at the counter maximum.

		// Random part. The second phase pauses the sender mid-way until every
		// result is back, and the fourth runs without any idling on either side.
		run_phase(64, PHASE_ITEMS, 1'b0);
		run_phase(1, PHASE_ITEMS, 1'b1);
		run_phase(0, PHASE_ITEMS, 1'b0);
		calm <= 1'b1;
		run_phase(17, PHASE_ITEMS, 1'b0);
		calm <= 1'b0;
		run_phase(127, PHASE_ITEMS, 1'b0);
		run_phase(3, PHASE_ITEMS, 1'b0);
		run_phase(40, PHASE_ITEMS, 1'b0);
		run_phase(65, PHASE_ITEMS, 1'b0);

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
